### rtl/vertex_transform_clip_test_unit_defines.svh
// Assertion macros for the vertex transform and clip test unit
`ifndef VERTEX_TRANSFORM_CLIP_TEST_UNIT_DEFINES_SVH
`define VERTEX_TRANSFORM_CLIP_TEST_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define VTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define VTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/vtc_pkg.sv
// Shared types and constants for the vertex transform and clip test unit
`default_nettype none

package vtc_pkg;

    localparam int ACTION_W    = 2;
    localparam int INDEX_W     = 4;
    localparam int ELEM_W      = 32;
    localparam int VERT_W      = 32;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int FRAC_BITS   = 16;
    localparam int MEM_DEPTH   = 32;
    localparam int MEM_AW      = 5;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 8;

    localparam logic [ACTION_W-1:0] ACT_LOAD_MV = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_PJ = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TEST    = 2'd2;

    // half an LSB of Q16.16 in the Q34.32 accumulator
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic       pass;
        logic [1:0] row;
    } vtc_row_t;

    typedef struct packed {
        vtc_row_t   dst;
        logic [1:0] col;
    } vtc_tag_t;

endpackage

`default_nettype wire

### rtl/vtc_matrix_mem.sv
// Matrix element store: one write port, one registered read port
`default_nettype none

module vtc_matrix_mem
(
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [vtc_pkg::MEM_AW-1:0]    wr_addr,
    input  wire logic [vtc_pkg::ELEM_W-1:0]    wr_data,
    input  wire logic                          rd_en,
    input  wire logic [vtc_pkg::MEM_AW-1:0]    rd_addr,
    output logic      [vtc_pkg::ELEM_W-1:0]    rd_data
);

    logic [vtc_pkg::ELEM_W-1:0] mem [vtc_pkg::MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/vtc_mac.sv
// Shared multiply-accumulate unit with Q16.16 rounding and saturation
`default_nettype none

module vtc_mac
#(
    parameter int SAT_W = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire vtc_pkg::vtc_tag_t                 in_tag,
    input  wire logic signed [vtc_pkg::ELEM_W-1:0] a,
    input  wire logic signed [vtc_pkg::ELEM_W-1:0] b,
    output logic                                   res_valid,
    output vtc_pkg::vtc_row_t                      res_row,
    output logic signed [SAT_W-1:0]                res_val
);

    localparam int RND_W = vtc_pkg::ACC_W - vtc_pkg::FRAC_BITS;

    logic                                  prod_v_reg;
    vtc_pkg::vtc_tag_t                     prod_tag_reg;
    logic signed [vtc_pkg::PROD_W-1:0]     prod_reg;
    logic signed [vtc_pkg::PROD_W-1:0]     prod_next;

    logic                                  acc_done_reg;
    logic                                  acc_done_next;
    vtc_pkg::vtc_row_t                     acc_row_reg;
    logic signed [vtc_pkg::ACC_W-1:0]      acc_reg;
    logic signed [vtc_pkg::ACC_W-1:0]      acc_next;

    logic                                  res_valid_reg;
    vtc_pkg::vtc_row_t                     res_row_reg;
    logic signed [SAT_W-1:0]               res_val_reg;
    logic signed [SAT_W-1:0]               res_val_next;

    logic signed [RND_W-1:0]               rnd;
    logic                                  fits;

    assign prod_next = a * b;

    // first column starts from the rounding bias
    always_comb
    begin
        acc_next = ((prod_tag_reg.col == 2'd0) ? vtc_pkg::ROUND_BIAS : acc_reg)
                   + vtc_pkg::ACC_W'(prod_reg);
        acc_done_next = prod_v_reg && (prod_tag_reg.col == 2'd3);
    end

    always_comb
    begin
        rnd  = acc_reg[vtc_pkg::ACC_W-1:vtc_pkg::FRAC_BITS];
        fits = (rnd[RND_W-1:SAT_W-1] == '0) || (rnd[RND_W-1:SAT_W-1] == '1);
        if (fits)
        begin
            res_val_next = rnd[SAT_W-1:0];
        end
        else if (rnd[RND_W-1])
        begin
            res_val_next = {1'b1, {(SAT_W-1){1'b0}}};
        end
        else
        begin
            res_val_next = {1'b0, {(SAT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg    <= 1'b0;
            acc_done_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg    <= in_valid;
            acc_done_reg  <= acc_done_next;
            res_valid_reg <= acc_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg     <= prod_next;
            prod_tag_reg <= in_tag;
        end
        if (prod_v_reg)
        begin
            acc_reg     <= acc_next;
            acc_row_reg <= prod_tag_reg.dst;
        end
        if (acc_done_reg)
        begin
            res_val_reg <= res_val_next;
            res_row_reg <= acc_row_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_row   = res_row_reg;
    assign res_val   = res_val_reg;

endmodule

`default_nettype wire

### rtl/vtc_clip.sv
// Viewing-volume test on the transformed vertex
`default_nettype none

module vtc_clip
#(
    parameter int SAT_W = 32
)
(
    input  wire logic signed [SAT_W-1:0] cx,
    input  wire logic signed [SAT_W-1:0] cy,
    input  wire logic signed [SAT_W-1:0] cz,
    input  wire logic signed [SAT_W-1:0] cw,
    output logic                         in_vol
);

    logic [SAT_W:0] ax;
    logic [SAT_W:0] ay;
    logic [SAT_W:0] az;
    logic [SAT_W:0] aw;

    function automatic logic [SAT_W:0] abs_val(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W:0] e;
        e = (SAT_W+1)'(v);
        return e[SAT_W] ? (SAT_W+1)'(-e) : e;
    endfunction

    always_comb
    begin
        ax     = abs_val(cx);
        ay     = abs_val(cy);
        az     = abs_val(cz);
        aw     = abs_val(cw);
        in_vol = !((ax > aw) || (ay > aw) || (az > aw));
    end

endmodule

`default_nettype wire

### rtl/vertex_transform_clip_test_unit.sv
// Vertex transform and clip test unit: top level with sequencer and output register
//
// Input channel s_*: one transaction per item. s_tuser carries the action:
// load a modelview element, load a projection element, or test a vertex.
// Element loads go straight into the matrix store and give no result.
// Action code 3 is accepted and dropped. A test reads the 32 matrix
// elements from the store in order through one shared multiplier-accumulator:
// 16 products for the modelview pass, a drain, 16 for the projection pass,
// a drain, then one compare step. s_tready returns in the same cycle as
// the result shows on m_*; no new item is taken before then.
// The store's single read port and the dependency between the two passes
// serialize the work; one item is processed at a time.
// Output channel m_*: one transaction per test, m_tdata bit 0 = inside.
// The result sits in an output register; a new load or test is taken while
// it waits. If a second test finishes while m_tready is still low, the unit
// holds in its compare step until the register frees.
// Reset clears control state only; matrix contents are undefined until
// loaded.
`default_nettype none
`include "vertex_transform_clip_test_unit_defines.svh"

module vertex_transform_clip_test_unit
#(
    parameter int COORD_WIDTH = 32
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [3:0] element_index, [35:4] element_value, [67:36] vertex_x,
    // [99:68] vertex_y, [131:100] vertex_z, [163:132] vertex_w, [167:164] zero
    input  wire logic [vtc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] action
    input  wire logic [vtc_pkg::ACTION_W-1:0]       s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] inside_res, [7:1] zero
    output logic [vtc_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_P1    = 3'd1;
    localparam logic [2:0] ST_WAIT1 = 3'd2;
    localparam logic [2:0] ST_P2    = 3'd3;
    localparam logic [2:0] ST_WAIT2 = 3'd4;
    localparam logic [2:0] ST_CMP   = 3'd5;

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [vtc_pkg::MEM_AW-1:0]        cnt_reg;
    logic [vtc_pkg::MEM_AW-1:0]        cnt_next;

    logic                              accept;
    logic [vtc_pkg::INDEX_W-1:0]       element_index;
    logic [vtc_pkg::ELEM_W-1:0]        element_value;
    logic signed [vtc_pkg::VERT_W-1:0] vin [4];

    logic                              wr_en;
    logic                              issue;
    logic                              iss_v_reg;
    vtc_pkg::vtc_tag_t                 iss_tag_reg;
    vtc_pkg::vtc_tag_t                 iss_tag_next;
    logic [vtc_pkg::ELEM_W-1:0]        rd_data;

    logic signed [vtc_pkg::VERT_W-1:0] v_reg [4];
    logic signed [SAT_W-1:0]           t_reg [4];
    logic signed [SAT_W-1:0]           c_reg [4];
    logic signed [vtc_pkg::ELEM_W-1:0] mac_b;

    logic                              res_valid;
    vtc_pkg::vtc_row_t                 res_row;
    logic signed [SAT_W-1:0]           res_val;
    logic                              row3_done;

    logic                              in_vol;
    logic                              out_load;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_inside_reg;

    assign element_index = s_tdata[3:0];
    assign element_value = s_tdata[35:4];
    assign vin[0]        = s_tdata[67:36];
    assign vin[1]        = s_tdata[99:68];
    assign vin[2]        = s_tdata[131:100];
    assign vin[3]        = s_tdata[163:132];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && ((s_tuser == vtc_pkg::ACT_LOAD_MV)
                                 || (s_tuser == vtc_pkg::ACT_LOAD_PJ));
    assign issue    = (state_reg == ST_P1) || (state_reg == ST_P2);

    assign iss_tag_next = {cnt_reg[4], cnt_reg[3:2], cnt_reg[1:0]};
    assign row3_done    = res_valid && (res_row.row == 2'd3);
    assign out_load     = (state_reg == ST_CMP) && (!out_valid_reg || m_tready);

    // loads only happen while idle, reads only while running: no overlap
    vtc_matrix_mem u_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr ({(s_tuser == vtc_pkg::ACT_LOAD_PJ), element_index}),
        .wr_data (element_value),
        .rd_en   (issue),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (iss_tag_reg.dst.pass)
        begin
            mac_b = vtc_pkg::ELEM_W'(t_reg[iss_tag_reg.col]);
        end
        else
        begin
            mac_b = v_reg[iss_tag_reg.col];
        end
    end

    vtc_mac #(.SAT_W(SAT_W)) u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iss_v_reg),
        .in_tag    (iss_tag_reg),
        .a         (rd_data),
        .b         (mac_b),
        .res_valid (res_valid),
        .res_row   (res_row),
        .res_val   (res_val)
    );

    vtc_clip #(.SAT_W(SAT_W)) u_clip
    (
        .cx     (c_reg[0]),
        .cy     (c_reg[1]),
        .cz     (c_reg[2]),
        .cw     (c_reg[3]),
        .in_vol (in_vol)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = issue ? cnt_reg + 1'b1 : cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == vtc_pkg::ACT_TEST))
                begin
                    state_next = ST_P1;
                    cnt_next   = '0;
                end
            end
            ST_P1:
            begin
                if (cnt_reg[3:0] == 4'hF)
                begin
                    state_next = ST_WAIT1;
                end
            end
            ST_WAIT1:
            begin
                if (row3_done)
                begin
                    state_next = ST_P2;
                end
            end
            ST_P2:
            begin
                if (cnt_reg[3:0] == 4'hF)
                begin
                    state_next = ST_WAIT2;
                end
            end
            ST_WAIT2:
            begin
                if (row3_done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            iss_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            iss_v_reg     <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (s_tuser == vtc_pkg::ACT_TEST))
        begin
            v_reg <= vin;
        end
        if (issue)
        begin
            iss_tag_reg <= iss_tag_next;
        end
        if (res_valid)
        begin
            if (res_row.pass)
            begin
                c_reg[res_row.row] <= res_val;
            end
            else
            begin
                t_reg[res_row.row] <= res_val;
            end
        end
        if (out_load)
        begin
            out_inside_reg <= in_vol;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(vtc_pkg::OUT_TDATA_W-1){1'b0}}, out_inside_reg};

    `VTC_ASSERT_SAME(a_idle_drained, s_tready, (!iss_v_reg && !res_valid), "input taken while busy")
    `VTC_ASSERT_SAME(a_row3_in_wait, row3_done, (state_reg == ST_WAIT1 || state_reg == ST_WAIT2), "last row outside drain")
    `VTC_ASSERT_NEXT(a_cmp_loads_out, out_load, (m_tvalid && state_reg == ST_IDLE), "result not registered")

endmodule

`default_nettype wire
